>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the console writer rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition a at an edge implies condition b at the same edge
`define ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// condition a at an edge implies condition b at the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

>>> rtl/core/tccw_pkg.sv
// ---------------------------------------------------------------------------
// tccw_pkg
// types, constants and helpers of the text console character writer
// ---------------------------------------------------------------------------
package tccw_pkg;

  // screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;

  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int IDX_W = 11;
  localparam int CHR_W = 8;
  localparam int ATR_W = 8;
  localparam int VAL_W = 16;

  // character codes
  localparam logic [CHR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHR_W-1:0] CH_BLANK   = 8'h20;

  // attribute after reset: black on white
  localparam logic [ATR_W-1:0] BASE_ATTR_RST = 8'hF0;

  // register index of the base attribute
  localparam logic REG_BASE_ATTR = 1'b0;

  // result kinds
  localparam logic ACT_CELL = 1'b0;
  localparam logic ACT_FILL = 1'b1;

  typedef enum logic [1:0] {
    REQ_PUT    = 2'd0,
    REQ_SETCUR = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CELL,
    ST_FILL
  } state_t;

  // one request as it arrives
  typedef struct packed {
    req_t             req;
    logic [CHR_W-1:0] char_code;
    logic             use_override;
    logic [ATR_W-1:0] item_color;
    logic [ROW_W-1:0] new_row;
    logic [COL_W-1:0] new_col;
  } item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic newline;
    logic set_cur;
    logic emit_cell;
    logic fill;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_t req;
    logic ch_zero;
    logic ch_newline;
    logic tab_more;
    logic cell_fill;
    logic nl_fill;
    logic out_free;
  } sts_t;

  // true when the column lies on a tab stop
  function automatic logic on_tab_stop(input logic [COL_W-1:0] col);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < (1 << COL_W); k += TAB_STOP) begin
      if (col == COL_W'(k)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

>>> rtl/core/tccw_ctrl.sv
// ---------------------------------------------------------------------------
// tccw_ctrl
// request sequencer: decodes a request and steps through its cell and fill writes
// ---------------------------------------------------------------------------
module tccw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  tccw_pkg::sts_t  sts,
  output logic            idle,
  output tccw_pkg::cmd_t  cmd
);

  tccw_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tccw_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tccw_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = tccw_pkg::ST_EXEC;
      end
      tccw_pkg::ST_EXEC: begin
        unique case (sts.req)
          tccw_pkg::REQ_PUT: begin
            if (sts.ch_zero)         state_nxt = tccw_pkg::ST_IDLE;
            else if (sts.ch_newline) state_nxt = sts.nl_fill ? tccw_pkg::ST_FILL
                                                             : tccw_pkg::ST_IDLE;
            else                     state_nxt = tccw_pkg::ST_CELL;
          end
          tccw_pkg::REQ_CLEAR: state_nxt = tccw_pkg::ST_FILL;
          default:             state_nxt = tccw_pkg::ST_IDLE;
        endcase
      end
      tccw_pkg::ST_CELL: begin
        if (sts.out_free) begin
          if (sts.tab_more)       state_nxt = tccw_pkg::ST_CELL;
          else if (sts.cell_fill) state_nxt = tccw_pkg::ST_FILL;
          else                    state_nxt = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_FILL: begin
        if (sts.out_free) state_nxt = tccw_pkg::ST_IDLE;
      end
      default: state_nxt = tccw_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    unique case (state_r)
      tccw_pkg::ST_IDLE: begin
        idle     = 1'b1;
        cmd.load = in_fire;
      end
      tccw_pkg::ST_EXEC: begin
        cmd.newline = (sts.req == tccw_pkg::REQ_PUT) && sts.ch_newline && !sts.ch_zero;
        cmd.set_cur = (sts.req == tccw_pkg::REQ_SETCUR);
      end
      tccw_pkg::ST_CELL: cmd.emit_cell = sts.out_free;
      tccw_pkg::ST_FILL: cmd.fill = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/core/tccw_dp.sv
// ---------------------------------------------------------------------------
// tccw_dp
// cursor datapath: holds the request, the cursor and the result register
// ---------------------------------------------------------------------------
module tccw_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tccw_pkg::cmd_t                     cmd,
  input  tccw_pkg::item_t                    item,
  input  logic [tccw_pkg::ATR_W-1:0]         base_attr,
  input  logic                               out_tready,
  output tccw_pkg::sts_t                     sts,
  output logic [tccw_pkg::ROW_W-1:0]         cur_row,
  output logic [tccw_pkg::COL_W-1:0]         cur_col,
  output logic                               out_valid,
  output logic                               out_action,
  output logic [tccw_pkg::IDX_W-1:0]         out_index,
  output logic [tccw_pkg::VAL_W-1:0]         out_value,
  output logic                               out_last
);

  // latched request
  tccw_pkg::req_t                 req_r;
  logic [tccw_pkg::CHR_W-1:0]     ch_r;
  logic [tccw_pkg::ATR_W-1:0]     attr_r;
  logic [tccw_pkg::ROW_W-1:0]     nrow_r;
  logic [tccw_pkg::COL_W-1:0]     ncol_r;

  // cursor
  logic [tccw_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [tccw_pkg::COL_W-1:0]     col_r, col_nxt;

  // result register
  logic                           valid_r;
  logic                           action_r;
  logic [tccw_pkg::IDX_W-1:0]     index_r;
  logic [tccw_pkg::VAL_W-1:0]     value_r;
  logic                           last_r;

  logic [tccw_pkg::COL_W-1:0]     col_inc;
  logic [tccw_pkg::ROW_W-1:0]     row_inc;
  logic                           ch_tab;
  logic                           wrap;
  logic [tccw_pkg::ROW_W-1:0]     row_wrap;
  logic                           tab_more;
  logic                           cell_fill;
  logic                           pos_ok;
  logic [tccw_pkg::IDX_W-1:0]     cell_idx;
  logic [tccw_pkg::CHR_W-1:0]     cell_ch;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= item.req;
      ch_r   <= item.char_code;
      attr_r <= item.use_override ? item.item_color : base_attr;
      nrow_r <= item.new_row;
      ncol_r <= item.new_col;
    end
  end

  // cursor arithmetic
  always_comb begin
    col_inc   = col_r + 1'b1;
    row_inc   = row_r + 1'b1;
    ch_tab    = (ch_r == tccw_pkg::CH_TAB);
    wrap      = (col_inc >= tccw_pkg::COL_W'(tccw_pkg::COLUMNS));
    row_wrap  = wrap ? row_inc : row_r;
    tab_more  = ch_tab && !tccw_pkg::on_tab_stop(col_inc) && !wrap;
    cell_fill = !tab_more && (row_wrap >= tccw_pkg::ROW_W'(tccw_pkg::ROWS));
    pos_ok    = (nrow_r < tccw_pkg::ROW_W'(tccw_pkg::ROWS)) &&
                (ncol_r < tccw_pkg::COL_W'(tccw_pkg::COLUMNS));
    cell_idx  = tccw_pkg::IDX_W'(row_r) * tccw_pkg::IDX_W'(tccw_pkg::COLUMNS) +
                tccw_pkg::IDX_W'(col_r);
    cell_ch   = ch_tab ? tccw_pkg::CH_BLANK : ch_r;
  end

  // next cursor position
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    priority if (cmd.fill) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (cmd.emit_cell) begin
      row_nxt = row_wrap;
      col_nxt = wrap ? '0 : col_inc;
    end else if (cmd.newline) begin
      row_nxt = row_inc;
      col_nxt = '0;
    end else if (cmd.set_cur && pos_ok) begin
      row_nxt = nrow_r;
      col_nxt = ncol_r;
    end else begin
      row_nxt = row_r;
      col_nxt = col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // result register, refilled as it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (cmd.emit_cell || cmd.fill) valid_r <= 1'b1;
    else if (out_tready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      action_r <= tccw_pkg::ACT_FILL;
      index_r  <= '0;
      value_r  <= {attr_r, tccw_pkg::CH_BLANK};
      last_r   <= 1'b1;
    end else if (cmd.emit_cell) begin
      action_r <= tccw_pkg::ACT_CELL;
      index_r  <= cell_idx;
      value_r  <= {attr_r, cell_ch};
      last_r   <= !tab_more && !cell_fill;
    end
  end

  // status to controller
  always_comb begin
    sts.req        = req_r;
    sts.ch_zero    = (ch_r == tccw_pkg::CH_NUL);
    sts.ch_newline = (ch_r == tccw_pkg::CH_NEWLINE);
    sts.tab_more   = tab_more;
    sts.cell_fill  = cell_fill;
    sts.nl_fill    = (row_inc >= tccw_pkg::ROW_W'(tccw_pkg::ROWS));
    sts.out_free   = !valid_r || out_tready;
  end

  assign cur_row    = row_r;
  assign cur_col    = col_r;
  assign out_valid  = valid_r;
  assign out_action = action_r;
  assign out_index  = index_r;
  assign out_value  = value_r;
  assign out_last   = last_r;

endmodule

>>> rtl/core/text_console_char_writer.sv
// ---------------------------------------------------------------------------
// text_console_char_writer
// text-mode console cursor engine turning requests into screen cell writes
// ---------------------------------------------------------------------------
// One request is handled at a time. A request is taken when in_tready is
// high, decoded in the following cycle, and then each result (cell write or
// screen fill) goes through the single output register. Set-cursor and
// ignored requests give no result; a newline or a cell write that scrolls off the
// last row ends in a screen fill. The sequencer in tccw_ctrl steps through
// the results. A result waits in the output register until it is taken, and
// the next result holds until then; a full screen clear is one result with
// action set, not a cell sweep.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_char_writer (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // char_code[7:0], use_override[8], item_color[16:9], new_row[21:17],
  // new_col[28:22], zero fill above
  input  logic [31:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_index[10:0], cell_value[26:11], zero fill above
  output logic [31:0] out_tdata,
  // action[0]
  output logic        out_tuser,
  output logic        out_tlast,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tccw_pkg::item_t                 item;
  tccw_pkg::cmd_t                  cmd;
  tccw_pkg::sts_t                  sts;
  logic                            idle;
  logic                            in_fire;
  logic [tccw_pkg::ATR_W-1:0]      base_attr_r;
  logic [tccw_pkg::ROW_W-1:0]      cur_row;
  logic [tccw_pkg::COL_W-1:0]      cur_col;
  logic                            out_action;
  logic [tccw_pkg::IDX_W-1:0]      out_index;
  logic [tccw_pkg::VAL_W-1:0]      out_value;
  logic                            cfg_wr;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == tccw_pkg::REG_BASE_ATTR);

  always_ff @(posedge clk) begin
    if (!rst_n)      base_attr_r <= tccw_pkg::BASE_ATTR_RST;
    else if (cfg_wr) base_attr_r <= cfg_pwdata[tccw_pkg::ATR_W-1:0];
  end

  assign cfg_prdata = (cfg_paddr[2] == tccw_pkg::REG_BASE_ATTR) ?
                      {24'b0, base_attr_r} : 32'b0;

  // request unpacking
  always_comb begin
    item.req          = tccw_pkg::req_t'(in_tuser);
    item.char_code    = in_tdata[7:0];
    item.use_override = in_tdata[8];
    item.item_color   = in_tdata[16:9];
    item.new_row      = in_tdata[21:17];
    item.new_col      = in_tdata[28:22];
  end

  assign in_tready = idle;
  assign in_fire   = in_tvalid && idle;

  tccw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .idle    (idle),
    .cmd     (cmd)
  );

  tccw_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .item          (item),
    .base_attr     (base_attr_r),
    .out_tready    (out_tready),
    .sts           (sts),
    .cur_row       (cur_row),
    .cur_col       (cur_col),
    .out_valid     (out_tvalid),
    .out_action    (out_action),
    .out_index     (out_index),
    .out_value     (out_value),
    .out_last      (out_tlast)
  );

  // result packing
  assign out_tuser = out_action;
  assign out_tdata = {5'b0, out_value, out_index};

  // checks
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_SAME(a_fill_is_last, clk, rst_n, out_tvalid && out_tuser, out_tlast && (out_tdata[10:0] == 11'd0))
  `ASSERT_SAME(a_cursor_on_screen, clk, rst_n, in_tready, (cur_row < tccw_pkg::ROW_W'(tccw_pkg::ROWS)) && (cur_col < tccw_pkg::COL_W'(tccw_pkg::COLUMNS)))
  `ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit_cell || cmd.fill, out_tvalid)

endmodule
